// ----- rtl/core/pbu_pkg.sv -----
// Shared types and constants for the permutation bitstream unranker.
package pbu_pkg;

  localparam int CARD_COUNT  = 52;
  localparam int CARD_W      = 6;
  localparam int START_WIDTH = 6;
  localparam int MAX_RESULTS = 6;
  localparam int BYTE_W      = 8;

  localparam int CHUNK_W     = 8;
  localparam int CHUNKS      = (CARD_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W       = CHUNKS * CHUNK_W;
  localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int EMIT_W      = $clog2(CARD_COUNT + 1);

  // A deck whose size is a power of two starts one bit narrower.
  localparam int FIRST_WIDTH =
      ((CARD_COUNT & (CARD_COUNT - 1)) == 0) ? START_WIDTH - 1 : START_WIDTH;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_record;
  } in_word_t;

  typedef struct packed {
    logic [CARD_W-1:0] card_index;
    logic [CARD_W-1:0] card_position;
    logic              deck_done;
    logic              out_of_range;
    logic              last_of_burst;
  } out_word_t;

  function automatic logic [PAD_W-1:0] all_cards();
    logic [PAD_W-1:0] r;
    for (int i = 0; i < PAD_W; i++) begin
      r[i] = (i < CARD_COUNT);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/permutation_bitstream_unranker.sv -----
// Permutation unranker: record bytes in, one word per decoded card out.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+------------------------------
//   byte in  | byte_valid  | byte_stall  | byte_word (in_word_t)
//   card out | card_valid  | card_stall  | card_word (out_word_t)
//
// Record bits are taken one per cycle, MSB first, pausing while a card is scanned and
// posted. A byte with no card goes from acceptance to the next through the accept step, the
// bit steps (a first byte carries only bit 0), a step to close the bits and a flush step.
// Each decoded card adds a scan of the available mask, eight indices per cycle, and a put step to post the word.
// Output is card_word plus one pending word; while a held word fills both, the next card
// waits to post and the byte waits in flush. byte_stall is high in reset and while a
// byte is in work. Reset is synchronous; the block then waits for a first byte.
module permutation_bitstream_unranker (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  pbu_pkg::in_word_t byte_word,
  output logic              card_valid,
  input  logic              card_stall,
  output pbu_pkg::out_word_t card_word
);
  import pbu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BITS,
    S_SCAN,
    S_PUT,
    S_FLUSH
  } state_t;

  state_t                 state;
  logic [PAD_W-1:0]       mask;
  logic [EMIT_W-1:0]      emitted;
  logic [CARD_W-1:0]      acc;
  logic [2:0]             taken;
  logic [2:0]             width;
  logic                   finished;
  logic [BYTE_W-1:0]      byte_sr;
  logic [3:0]             bits_left;
  logic [CARD_W-1:0]      tgt;
  logic [CHUNK_IDX_W-1:0] chunk;
  logic [CARD_W-1:0]      last_idx;
  logic [2:0]             res_cnt;
  out_word_t              res_word;
  out_word_t              pend_word;
  logic                   pend_valid;

  logic [CHUNK_W-1:0] chunk_bits;
  logic [3:0]         chunk_cnt;
  logic [2:0]         hit_sel;
  logic [2:0]         top_sel;
  logic               hit;
  logic               scan_end;
  logic [CARD_W-1:0]  pick;
  logic [EMIT_W-1:0]  emitted_next;
  logic [EMIT_W-1:0]  n_left;
  logic               done_next;
  logic               pow2;
  logic [CARD_W-1:0]  acc_next;
  logic [2:0]         taken_next;
  logic               out_free;
  logic               card_load;

  function automatic logic [3:0] popcount8(logic [CHUNK_W-1:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

  function automatic logic [2:0] nth_set(logic [CHUNK_W-1:0] b, logic [3:0] k);
    logic [3:0] seen;
    logic [2:0] r;
    seen = '0;
    r    = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (b[i]) begin
        if (seen == k) r = 3'(i);
        seen = seen + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] top_set(logic [CHUNK_W-1:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  always_comb begin
    chunk_bits   = CHUNK_W'(mask >> {chunk, 3'b000});
    chunk_cnt    = popcount8(chunk_bits);
    hit          = {2'b00, chunk_cnt} > tgt;
    hit_sel      = nth_set(chunk_bits, tgt[3:0]);
    top_sel      = top_set(chunk_bits);
    scan_end     = hit || (chunk == CHUNK_IDX_W'(CHUNKS - 1));
    if (hit) begin
      pick = CARD_W'({chunk, hit_sel});
    end else if (chunk_bits != '0) begin
      pick = CARD_W'({chunk, top_sel});
    end else begin
      pick = last_idx;
    end
    emitted_next = emitted + EMIT_W'(1);
    done_next    = (emitted_next == EMIT_W'(CARD_COUNT));
    n_left       = EMIT_W'(CARD_COUNT) - emitted_next;
    pow2         = (n_left != '0) && ((n_left & (n_left - EMIT_W'(1))) == '0);
    acc_next     = {acc[CARD_W-2:0], byte_sr[BYTE_W-1]};
    taken_next   = taken + 3'd1;
    out_free     = !card_valid || !card_stall;
    card_load    = pend_valid && out_free &&
                   (((state == S_PUT) && (res_cnt < 3'(MAX_RESULTS))) ||
                    (state == S_FLUSH));
  end

  assign byte_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mask       <= all_cards();
      emitted    <= '0;
      acc        <= '0;
      taken      <= '0;
      width      <= 3'(START_WIDTH);
      finished   <= 1'b1;
      res_cnt    <= '0;
      pend_valid <= 1'b0;
      card_valid <= 1'b0;
    end else begin
      if (card_load) begin
        card_valid <= 1'b1;
      end else if (out_free) begin
        card_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (byte_valid) begin
            if (byte_word.first_of_record) begin
              mask      <= all_cards();
              emitted   <= '0;
              finished  <= 1'b0;
              width     <= 3'(FIRST_WIDTH);
              acc       <= '0;
              taken     <= '0;
              byte_sr   <= {byte_word.data_byte[0], {(BYTE_W-1){1'b0}}};
              bits_left <= 4'd1;
              state     <= S_BITS;
            end else if (!finished) begin
              byte_sr   <= byte_word.data_byte;
              bits_left <= 4'(BYTE_W);
              state     <= S_BITS;
            end
          end
        end
        S_BITS: begin
          if (bits_left == '0) begin
            state <= S_FLUSH;
          end else begin
            byte_sr   <= {byte_sr[BYTE_W-2:0], 1'b0};
            bits_left <= bits_left - 4'd1;
            acc       <= acc_next;
            taken     <= taken_next;
            if (taken_next >= width) begin
              tgt      <= acc_next;
              chunk    <= '0;
              last_idx <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chunk_bits != '0) last_idx <= CARD_W'({chunk, top_sel});
          if (scan_end) begin
            res_word.card_index    <= pick;
            res_word.card_position <= CARD_W'(emitted);
            res_word.deck_done     <= done_next;
            res_word.out_of_range  <= !hit;
            res_word.last_of_burst <= 1'b0;
            mask     <= mask & ~(PAD_W'(1) << pick);
            emitted  <= emitted_next;
            finished <= done_next;
            if (!done_next) begin
              if (pow2 && width != '0) width <= width - 3'd1;
              acc   <= '0;
              taken <= '0;
            end
            state <= S_PUT;
          end else begin
            tgt   <= tgt - {2'b00, chunk_cnt};
            chunk <= chunk + CHUNK_IDX_W'(1);
          end
        end
        S_PUT: begin
          if (res_cnt >= 3'(MAX_RESULTS) || !pend_valid || out_free) begin
            if (res_cnt < 3'(MAX_RESULTS)) begin
              if (pend_valid) begin
                card_word <= pend_word;
              end
              pend_word  <= res_word;
              pend_valid <= 1'b1;
              res_cnt    <= res_cnt + 3'd1;
            end
            if (finished) begin
              state <= S_FLUSH;
            end else if (width == '0) begin
              tgt      <= '0;
              chunk    <= '0;
              last_idx <= '0;
              state    <= S_SCAN;
            end else begin
              state <= S_BITS;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            res_cnt <= '0;
            state   <= S_IDLE;
          end else if (out_free) begin
            card_word.card_index    <= pend_word.card_index;
            card_word.card_position <= pend_word.card_position;
            card_word.deck_done     <= pend_word.deck_done;
            card_word.out_of_range  <= pend_word.out_of_range;
            card_word.last_of_burst <= 1'b1;
            pend_valid              <= 1'b0;
            res_cnt                 <= '0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/permutation_bitstream_unranker_test.sv -----
// Self-checking testbench for the permutation bitstream unranker: directed rows, then random records.
module permutation_bitstream_unranker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbu_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int PRESSURE_AT   = 25;
  localparam int PRESSURE_HOLD = 300;
  localparam int RANDOM_ITEMS  = 80;
  localparam int RECORD_BYTES  = 31;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              pinned;
    logic [2:0]        n_cards;
    out_word_t         card;
  } stim_row_t;

  typedef struct {
    bit        pinned;
    int        n_cards;
    out_word_t card;
  } row_note_t;

  localparam int N_ROWS = 20;

  // pinned rows carry their expected card; the rest go through the decoder model
  stim_row_t directed_rows [N_ROWS] = '{
    '{8'hFF, 1'b0, 1'b1, 3'd0, '0},
    '{8'h00, 1'b0, 1'b1, 3'd0, '0},
    '{8'h01, 1'b1, 1'b1, 3'd0, '0},
    '{8'hFF, 1'b0, 1'b1, 3'd1, '{6'd51, 6'd0, 1'b0, 1'b1, 1'b1}},
    '{8'hFE, 1'b1, 1'b1, 3'd0, '0},
    '{8'h00, 1'b0, 1'b1, 3'd1, '{6'd0, 6'd0, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b0, 1'b0, 3'd0, '0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, '0},
    '{8'hAA, 1'b0, 1'b0, 3'd0, '0},
    '{8'h55, 1'b0, 1'b0, 3'd0, '0},
    '{8'h80, 1'b0, 1'b0, 3'd0, '0},
    '{8'h7F, 1'b0, 1'b0, 3'd0, '0},
    '{8'h80, 1'b1, 1'b1, 3'd0, '0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, '0},
    '{8'h00, 1'b0, 1'b0, 3'd0, '0},
    '{8'hC3, 1'b0, 1'b0, 3'd0, '0},
    '{8'h3C, 1'b0, 1'b0, 3'd0, '0},
    '{8'hFF, 1'b1, 1'b1, 3'd0, '0},
    '{8'h00, 1'b1, 1'b1, 3'd0, '0},
    '{8'h01, 1'b0, 1'b0, 3'd0, '0}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_word = '0;
  logic      card_valid;
  logic      card_stall = 1'b0;
  out_word_t card_word;

  permutation_bitstream_unranker uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .card_valid (card_valid),
    .card_stall (card_stall),
    .card_word  (card_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder model state
  logic [CARD_COUNT-1:0] free_cards = '1;
  int unsigned           placed     = 0;
  int unsigned           field_acc  = 0;
  int unsigned           field_got  = 0;
  int unsigned           field_len  = START_WIDTH;
  bit                    deck_idle  = 1'b1;
  out_word_t             burst_cards [$];

  out_word_t expected_cards [$];
  row_note_t row_notes [$];
  int        errors      = 0;
  int        idle_cycles = 0;

  function automatic void open_field();
    int unsigned left;
    left = CARD_COUNT - placed;
    if (left != 0 && (left & (left - 1)) == 0 && field_len > 0) field_len--;
    field_acc = 0;
    field_got = 0;
  endfunction

  function automatic void place_card(int unsigned v);
    int unsigned seen;
    int unsigned pick;
    int unsigned last;
    bit          found;
    bit          any;
    out_word_t   w;
    seen  = 0;
    pick  = 0;
    last  = 0;
    found = 1'b0;
    any   = 1'b0;
    for (int i = 0; i < CARD_COUNT; i++) begin
      if (free_cards[i]) begin
        any  = 1'b1;
        last = i;
        if (!found) begin
          if (seen == v) begin
            pick  = i;
            found = 1'b1;
          end
          seen++;
        end
      end
    end
    if (!found) pick = any ? last : 0;
    free_cards[pick] = 1'b0;
    placed++;
    deck_idle = (placed >= CARD_COUNT);
    if (burst_cards.size() < MAX_RESULTS) begin
      w.card_index    = pick[CARD_W-1:0];
      w.card_position = placed[CARD_W-1:0] - CARD_W'(1);
      w.deck_done     = deck_idle;
      w.out_of_range  = !found;
      w.last_of_burst = 1'b0;
      burst_cards.push_back(w);
    end
    if (!deck_idle) open_field();
  endfunction

  function automatic void flush_zero_width();
    while (!deck_idle && field_len == 0) place_card(0);
  endfunction

  function automatic void shift_bit(logic b);
    if (deck_idle) return;
    field_acc = ((field_acc << 1) | 32'(b)) & 32'h3F;
    field_got++;
    if (field_got >= field_len) begin
      place_card(field_acc);
      flush_zero_width();
    end
  endfunction

  function automatic void decode_byte(in_word_t w);
    burst_cards.delete();
    if (w.first_of_record) begin
      free_cards = '1;
      placed     = 0;
      deck_idle  = 1'b0;
      field_len  = START_WIDTH;
      open_field();
      flush_zero_width();
      shift_bit(w.data_byte[0]);
    end else if (!deck_idle) begin
      for (int i = BYTE_W - 1; i >= 0; i--) shift_bit(w.data_byte[i]);
    end
    if (burst_cards.size() > 0) burst_cards[$].last_of_burst = 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    row_note_t note;
    out_word_t exp_card;
    bit        moved;
    if (!rst) begin
      moved = 1'b0;
      if (byte_valid && !byte_stall) begin
        moved = 1'b1;
        note  = row_notes.pop_front();
        decode_byte(byte_word);
        if (note.pinned) begin
          for (int k = 0; k < note.n_cards; k++) expected_cards.push_back(note.card);
        end else begin
          foreach (burst_cards[k]) expected_cards.push_back(burst_cards[k]);
        end
      end
      if (card_valid && !card_stall) begin
        moved = 1'b1;
        if (expected_cards.size() == 0) begin
          $error("unexpected card word %p", card_word);
          errors++;
        end else begin
          exp_card = expected_cards.pop_front();
          if (card_word.card_index !== exp_card.card_index) begin
            $error("card_index: expected %0d, got %0d", exp_card.card_index,
                   card_word.card_index);
            errors++;
          end
          if (card_word.card_position !== exp_card.card_position) begin
            $error("card_position: expected %0d, got %0d", exp_card.card_position,
                   card_word.card_position);
            errors++;
          end
          if (card_word.deck_done !== exp_card.deck_done) begin
            $error("deck_done: expected %0b, got %0b", exp_card.deck_done,
                   card_word.deck_done);
            errors++;
          end
          if (card_word.out_of_range !== exp_card.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", exp_card.out_of_range,
                   card_word.out_of_range);
            errors++;
          end
          if (card_word.last_of_burst !== exp_card.last_of_burst) begin
            $error("last_of_burst: expected %0b, got %0b", exp_card.last_of_burst,
                   card_word.last_of_burst);
            errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic first, input int gap,
                           input row_note_t note);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_notes.push_back(note);
    byte_word  <= '{data_byte: data, first_of_record: first};
    byte_valid <= 1'b1;
    do @(posedge clk); while (byte_stall);
  endtask

  initial begin : byte_source
    row_note_t note;
    int        counted;
    int        kind;
    int        len;
    bit        quiet;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[r]) begin
      note.pinned  = directed_rows[r].pinned;
      note.n_cards = int'(directed_rows[r].n_cards);
      note.card    = directed_rows[r].card;
      send_byte(directed_rows[r].data, directed_rows[r].first, $urandom_range(0, 19), note);
    end
    note = '{pinned: 1'b0, n_cards: 0, card: '0};
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) len = 1 + RECORD_BYTES + $urandom_range(0, 3);   // whole deck, spare bytes
      else if (kind < 9) len = 1 + $urandom_range(0, RECORD_BYTES - 1);  // cut short
      else len = $urandom_range(1, 3);                               // stray bytes
      for (int b = 0; b < len; b++) begin
        quiet = (counted >= 30 && counted < 60);
        send_byte(BYTE_W'($urandom_range(0, 255)), (kind < 9) && (b == 0),
                  quiet ? 0 : $urandom_range(0, 19), note);
        if (kind < 9) counted++;
      end
    end
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_cards.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cards.size() != 0) begin
      $error("%0d card words never arrived", expected_cards.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS permutation_bitstream_unranker");
    end else begin
      $display("FAIL permutation_bitstream_unranker");
    end
    $finish;
  end

  initial begin : card_sink
    int  hold;
    int  taken;
    bit  pressed;
    taken   = 0;
    pressed = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressed && taken >= PRESSURE_AT) begin
        hold    = PRESSURE_HOLD;
        pressed = 1'b1;
      end else if (taken >= 60 && taken < 90) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold > 0) begin
        card_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      card_stall <= 1'b0;
      do @(posedge clk); while (!card_valid);
      taken++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL permutation_bitstream_unranker");
    $finish;
  end

endmodule
